// ----- rtl/mhpq_pkg.sv -----
// shared types and constants for the min-heap priority queue
// no dependencies; used by mhpq_node_cmp and min_heap_priority_queue_core
package mhpq_pkg;

    localparam int OUT_WIDTH    = 32;
    localparam int TOTAL_WIDTH  = 11;
    localparam int STATUS_WIDTH = 2;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // child selection for one sift-down level
    typedef struct packed {
        logic take_right;
        logic sink;
    } t_pick;

endpackage

// ----- rtl/mhpq_node_cmp.sv -----
// child select and compare for one level of the sift-down
// depends on mhpq_pkg (t_pick)
module mhpq_node_cmp #(
    parameter int DATA_WIDTH = 32
) (
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    input  logic                  i_has_right,
    input  logic [DATA_WIDTH-1:0] i_hole,
    output mhpq_pkg::t_pick       o_pick,
    output logic [DATA_WIDTH-1:0] o_value
);

    logic take_right;

    // right child only when strictly smaller
    assign take_right      = i_has_right && ($signed(i_right) < $signed(i_left));
    assign o_value         = take_right ? i_right : i_left;
    assign o_pick.take_right = take_right;
    assign o_pick.sink     = $signed(o_value) < $signed(i_hole);

endmodule

// ----- rtl/min_heap_priority_queue_core.sv -----
// min-heap priority queue: push / pop of signed values, one result item per item
// a push sifts the new value up, a pop sifts the last entry down from the root; at most 10 levels (CAPACITY 1024)
// throughput: one item at a time, busy high until the result cycle; o_done strobe, no stall
// reset (i_rst_n low, synchronous): count cleared, heap ram contents left as they are
// depends on mhpq_pkg and mhpq_node_cmp
module min_heap_priority_queue_core #(
    parameter int CAPACITY   = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_operation,
    input  logic signed [mhpq_pkg::OUT_WIDTH-1:0]  i_push_value,
    output logic                                   o_done,
    output logic signed [mhpq_pkg::OUT_WIDTH-1:0]  o_popped_value,
    output logic signed [mhpq_pkg::OUT_WIDTH-1:0]  o_top_value,
    output logic [mhpq_pkg::TOTAL_WIDTH-1:0]       o_entry_total,
    output logic [mhpq_pkg::STATUS_WIDTH-1:0]      o_status
);

    localparam int AW = $clog2(CAPACITY);       // heap address
    localparam int CW = $clog2(CAPACITY + 1);   // entry count, holds CAPACITY itself
    localparam int KW = AW + 1;                 // child index, may point past the end

    // one-hot sequencer
    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_UP_RD   = 8'b0000_0010,   // read parent of hole
        S_UP_CMP  = 8'b0000_0100,   // parent moves down or stop
        S_DN_LAST = 8'b0000_1000,   // last entry arrives, first child read
        S_DN_RD_R = 8'b0001_0000,   // left child arrives, right child read
        S_DN_CMP  = 8'b0010_0000,   // pick child, child moves up or stop
        S_PUT     = 8'b0100_0000,   // held value goes into the hole
        S_FIN     = 8'b1000_0000    // load result registers
    } t_state;

    // heap storage, one write and one registered read port
    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] r_rdata;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_pos, n_pos;       // current hole
    logic [AW-1:0]         r_kid, n_kid;       // parent on the way up, left child going down
    logic [DATA_WIDTH-1:0] r_val, n_val;       // value looking for its place
    logic [DATA_WIDTH-1:0] r_left, n_left;
    logic                  r_has_r, n_has_r;
    logic [DATA_WIDTH-1:0] r_root, n_root;     // copy of entry zero
    logic [DATA_WIDTH-1:0] r_popped, n_popped;
    mhpq_pkg::t_status     r_status, n_status;

    logic                              r_done;
    logic [mhpq_pkg::OUT_WIDTH-1:0]    r_out_popped;
    logic [mhpq_pkg::OUT_WIDTH-1:0]    r_out_top;
    logic [mhpq_pkg::TOTAL_WIDTH-1:0]  r_out_total;
    mhpq_pkg::t_status                 r_out_status;

    mhpq_pkg::t_pick       pick;
    logic [DATA_WIDTH-1:0] pick_value;
    logic [AW-1:0]         pick_idx;
    logic [KW-1:0]         kid_of_pos;     // first child of the hole
    logic [KW-1:0]         kid_of_pick;    // first child of the chosen child
    logic [KW-1:0]         kid_right;
    logic [KW-1:0]         count_ext;

    mhpq_node_cmp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_cmp (
        .i_left      (r_left),
        .i_right     (r_rdata),
        .i_has_right (r_has_r),
        .i_hole      (r_val),
        .o_pick      (pick),
        .o_value     (pick_value)
    );

    assign pick_idx    = r_kid + AW'(pick.take_right);
    assign kid_of_pos  = {r_pos, 1'b1};
    assign kid_of_pick = {pick_idx, 1'b1};
    assign kid_right   = KW'(r_kid) + KW'(1);
    assign count_ext   = KW'(r_count);

    // ram: a read hits the entry written in the same cycle only where its data goes unused;
    // the sequencer orders every read after the write it depends on
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_kid     = r_kid;
        n_val     = r_val;
        n_left    = r_left;
        n_has_r   = r_has_r;
        n_root    = r_root;
        n_popped  = r_popped;
        n_status  = r_status;
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_wdata = r_val;
        mem_raddr = r_kid;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_status = mhpq_pkg::ST_OK;
                    n_popped = '0;
                    if (!i_operation) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_status = mhpq_pkg::ST_FULL;
                            n_state  = S_FIN;
                        end else begin
                            // sign-extend or wrap to the stored width
                            n_val   = DATA_WIDTH'(i_push_value);
                            n_pos   = AW'(r_count);
                            n_count = r_count + CW'(1);
                            n_state = (r_count == '0) ? S_PUT : S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = mhpq_pkg::ST_EMPTY;
                            n_state  = S_FIN;
                        end else begin
                            n_popped  = r_root;
                            n_count   = r_count - CW'(1);
                            n_pos     = '0;
                            mem_raddr = AW'(r_count - CW'(1));
                            n_state   = (r_count == CW'(1)) ? S_FIN : S_DN_LAST;
                        end
                    end
                end
            end
            S_UP_RD: begin
                mem_raddr = (r_pos - AW'(1)) >> 1;
                n_kid     = (r_pos - AW'(1)) >> 1;
                n_state   = S_UP_CMP;
            end
            S_UP_CMP: begin
                if ($signed(r_val) < $signed(r_rdata)) begin
                    // parent moves down into the hole
                    mem_we    = 1'b1;
                    mem_waddr = r_pos;
                    mem_wdata = r_rdata;
                    n_pos     = r_kid;
                    n_state   = (r_kid == '0) ? S_PUT : S_UP_RD;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_DN_LAST: begin
                n_val = r_rdata;
                if (kid_of_pos < count_ext) begin
                    mem_raddr = kid_of_pos[AW-1:0];
                    n_kid     = kid_of_pos[AW-1:0];
                    n_state   = S_DN_RD_R;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_DN_RD_R: begin
                n_left    = r_rdata;
                n_has_r   = kid_right < count_ext;
                mem_raddr = kid_right[AW-1:0];
                n_state   = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (pick.sink) begin
                    // smaller child moves up into the hole
                    mem_we    = 1'b1;
                    mem_waddr = r_pos;
                    mem_wdata = pick_value;
                    if (r_pos == '0) begin
                        n_root = pick_value;
                    end
                    n_pos = pick_idx;
                    if (kid_of_pick < count_ext) begin
                        mem_raddr = kid_of_pick[AW-1:0];
                        n_kid     = kid_of_pick[AW-1:0];
                        n_state   = S_DN_RD_R;
                    end else begin
                        n_state = S_PUT;
                    end
                end else begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = r_val;
                if (r_pos == '0) begin
                    n_root = r_val;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= (r_state == S_FIN);
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_kid    <= n_kid;
        r_val    <= n_val;
        r_left   <= n_left;
        r_has_r  <= n_has_r;
        r_root   <= n_root;
        r_popped <= n_popped;
        r_status <= n_status;
    end

    // result registers; stored values leave as their low bits, zero-extended
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN) begin
            r_out_popped <= mhpq_pkg::OUT_WIDTH'($unsigned(r_popped));
            r_out_top    <= (r_count != '0) ? mhpq_pkg::OUT_WIDTH'($unsigned(r_root)) : '0;
            r_out_total  <= mhpq_pkg::TOTAL_WIDTH'(r_count);
            r_out_status <= r_status;
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_popped_value = $signed(r_out_popped);
    assign o_top_value    = $signed(r_out_top);
    assign o_entry_total  = r_out_total;
    assign o_status       = r_out_status;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_out_status == mhpq_pkg::ST_FULL) |-> (r_count == CW'(CAPACITY)))
        else $error("full status while heap not full");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_out_status == mhpq_pkg::ST_EMPTY)
            |-> (r_count == '0 && r_out_top == '0 && r_out_total == '0))
        else $error("empty status while heap holds entries");

    a_hole_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) |-> (CW'(r_pos) < r_count))
        else $error("final write outside the heap");
`endif

endmodule
